### rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define HSS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted
`define HSS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/hss_pkg.sv
// ----------------------------------------------------------------------------
// hss_pkg
// Shared types, codes and defaults of the substring search block.
// ----------------------------------------------------------------------------
package hss_pkg;

  // Default capacities
  localparam int TextMaxDef    = 1024;
  localparam int PatternMaxDef = 32;

  // Fixed field widths
  localparam int FuncW  = 2;
  localparam int ByteW  = 8;
  localparam int OffW   = 11;
  localparam int PosW   = 10;

  // Skip table covers every byte value
  localparam int SkipDepth = 256;

  // Transaction function codes
  localparam logic [FuncW-1:0] FUNC_CLEAR   = 2'd0;
  localparam logic [FuncW-1:0] FUNC_APP_PAT = 2'd1;
  localparam logic [FuncW-1:0] FUNC_APP_TXT = 2'd2;
  localparam logic [FuncW-1:0] FUNC_SEARCH  = 2'd3;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [ByteW-1:0] byte_value;
    logic [OffW-1:0]  start_offset;
  } hss_req_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] match_position;
    logic            overflow;
  } hss_res_t;

  // Datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_APP_PAT,
    OP_APP_TXT,
    OP_INIT,
    OP_FILL,
    OP_BLD_RD,
    OP_BLD_WR,
    OP_LOAD_J,
    OP_CMP_STEP,
    OP_SHIFT,
    OP_SCAN_NEXT,
    OP_HIT_OFF,
    OP_HIT_J,
    OP_MISS
  } hss_op_e;

  // Datapath status toward the controller
  typedef struct packed {
    logic pc_zero;
    logic pc_one;
    logic pc_gt_tc;
    logic off_lt_tc;
    logic k_lt_tc;
    logic j_lt_tc;
    logic fill_last;
    logic bld_last;
    logic byte_eq;
    logic pi_zero;
  } hss_stat_t;

endpackage

### rtl/hss_ram.sv
// ----------------------------------------------------------------------------
// hss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/hss_dpath.sv
// ----------------------------------------------------------------------------
// hss_dpath
// Stores, counters and compare logic of the search engine; acts on the
// command issued by the controller each cycle.
// ----------------------------------------------------------------------------
module hss_dpath import hss_pkg::*; #(
  parameter int TEXT_MAX    = TextMaxDef,
  parameter int PATTERN_MAX = PatternMaxDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hss_op_e   op_i,
  input  hss_req_t  req_i,
  output hss_stat_t stat_o,
  output hss_res_t  res_o
);

  localparam int CW  = $clog2(TEXT_MAX + 1);
  localparam int AW  = $clog2(TEXT_MAX);
  localparam int SW  = $clog2(PATTERN_MAX + 1);
  localparam int PAW = $clog2(PATTERN_MAX);
  localparam int KW  = ((CW > OffW) ? CW : OffW) + 2;
  localparam int SAW = $clog2(SkipDepth);

  logic [CW-1:0]  tc_q;
  logic [SW-1:0]  pc_q;
  logic           ovf_q;
  logic [OffW-1:0] off_q;
  logic [KW-1:0]  k_q, j_q;
  logic [PAW-1:0] pi_q;
  logic [SAW-1:0] fa_q;
  logic [SW-1:0]  bi_q;
  logic           first_q;
  logic [ByteW-1:0] tk_q;
  hss_res_t       res_q;

  logic           txt_we, pat_we, skp_we;
  logic [PAW-1:0] pat_raddr;
  logic [SAW-1:0] skp_waddr;
  logic [SW-1:0]  skp_wdata;
  logic [ByteW-1:0] txt_rdata, pat_rdata;
  logic [SW-1:0]  skp_rdata;

  // Store write enables and address muxes
  assign txt_we    = (op_i == OP_APP_TXT) && (tc_q < CW'(TEXT_MAX));
  assign pat_we    = (op_i == OP_APP_PAT) && (pc_q < SW'(PATTERN_MAX));
  assign skp_we    = (op_i == OP_FILL) || (op_i == OP_BLD_WR);
  assign skp_waddr = (op_i == OP_FILL) ? fa_q : pat_rdata;
  assign skp_wdata = (op_i == OP_FILL) ? pc_q : (pc_q - SW'(1) - bi_q);
  assign pat_raddr = (op_i == OP_BLD_RD) ? bi_q[PAW-1:0] : pi_q;

  hss_ram #(.WIDTH(ByteW), .DEPTH(TEXT_MAX)) u_text (
    .clk_i   (clk_i),
    .we_i    (txt_we),
    .waddr_i (tc_q[AW-1:0]),
    .wdata_i (req_i.byte_value),
    .raddr_i (j_q[AW-1:0]),
    .rdata_o (txt_rdata)
  );

  hss_ram #(.WIDTH(ByteW), .DEPTH(PATTERN_MAX)) u_pattern (
    .clk_i   (clk_i),
    .we_i    (pat_we),
    .waddr_i (pc_q[PAW-1:0]),
    .wdata_i (req_i.byte_value),
    .raddr_i (pat_raddr),
    .rdata_o (pat_rdata)
  );

  hss_ram #(.WIDTH(SW), .DEPTH(SkipDepth)) u_skip (
    .clk_i   (clk_i),
    .we_i    (skp_we),
    .waddr_i (skp_waddr),
    .wdata_i (skp_wdata),
    .raddr_i (tk_q),
    .rdata_o (skp_rdata)
  );

  // Fill counts and sticky overflow
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q  <= '0;
      pc_q  <= '0;
      ovf_q <= 1'b0;
    end else begin
      case (op_i)
        OP_CLEAR: begin
          tc_q  <= '0;
          pc_q  <= '0;
          ovf_q <= 1'b0;
        end
        OP_APP_PAT: begin
          if (pat_we) pc_q <= pc_q + SW'(1);
          else        ovf_q <= 1'b1;
        end
        OP_APP_TXT: begin
          if (txt_we) tc_q <= tc_q + CW'(1);
          else        ovf_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Search working registers and result
  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_INIT: begin
        off_q <= req_i.start_offset;
        k_q   <= KW'(req_i.start_offset) + KW'(pc_q) - KW'(1);
        j_q   <= KW'(req_i.start_offset);
        pi_q  <= '0;
        fa_q  <= '0;
        bi_q  <= '0;
      end
      OP_FILL:      fa_q <= fa_q + SAW'(1);
      OP_BLD_WR:    bi_q <= bi_q + SW'(1);
      OP_LOAD_J: begin
        j_q     <= k_q;
        pi_q    <= PAW'(pc_q - SW'(1));
        first_q <= 1'b1;
      end
      OP_CMP_STEP: begin
        // rightmost text byte of the window feeds the skip lookup
        if (first_q) begin
          tk_q    <= txt_rdata;
          first_q <= 1'b0;
        end
        if (stat_o.byte_eq) begin
          j_q  <= j_q - KW'(1);
          pi_q <= pi_q - PAW'(1);
        end
      end
      OP_SHIFT:     k_q <= k_q + KW'(skp_rdata);
      OP_SCAN_NEXT: j_q <= j_q + KW'(1);
      OP_HIT_OFF:   res_q <= '{found: 1'b1, match_position: off_q[PosW-1:0],
                               overflow: ovf_q};
      OP_HIT_J:     res_q <= '{found: 1'b1, match_position: j_q[PosW-1:0],
                               overflow: ovf_q};
      OP_MISS:      res_q <= '{found: 1'b0, match_position: '0, overflow: ovf_q};
      default: ;
    endcase
  end

  // Status toward the controller
  always_comb begin
    stat_o.pc_zero   = (pc_q == '0);
    stat_o.pc_one    = (pc_q == SW'(1));
    stat_o.pc_gt_tc  = (KW'(pc_q) > KW'(tc_q));
    stat_o.off_lt_tc = (KW'(off_q) < KW'(tc_q));
    stat_o.k_lt_tc   = (k_q < KW'(tc_q));
    stat_o.j_lt_tc   = (j_q < KW'(tc_q));
    stat_o.fill_last = (fa_q == SAW'(SkipDepth - 1));
    stat_o.bld_last  = (bi_q == (pc_q - SW'(2)));
    stat_o.byte_eq   = (txt_rdata == pat_rdata);
    stat_o.pi_zero   = (pi_q == '0);
  end

  assign res_o = res_q;

endmodule

### rtl/hss_ctrl.sv
// ----------------------------------------------------------------------------
// hss_ctrl
// Sequencer of the search: decodes transactions and steps the datapath
// through table build, window compare and shift.
// ----------------------------------------------------------------------------
module hss_ctrl import hss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [FuncW-1:0] func_i,
  input  hss_stat_t        stat_i,
  output hss_op_e          op_o,
  output logic             busy_o,
  output logic             done_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_FILL,
    ST_BLD_RD,
    ST_BLD_WR,
    ST_CHK,
    ST_CMP_RD,
    ST_CMP,
    ST_SKIP_RD,
    ST_SHIFT
  } state_e;

  state_e  state_q, state_d;
  hss_op_e op;
  logic    busy_q, done_q;
  logic    fin;

  // Next state and datapath command
  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (start_i && !busy_q) begin
          case (func_i)
            FUNC_CLEAR:   op = OP_CLEAR;
            FUNC_APP_PAT: op = OP_APP_PAT;
            FUNC_APP_TXT: op = OP_APP_TXT;
            default: begin
              op      = OP_INIT;
              state_d = ST_DECIDE;
            end
          endcase
        end
      end
      // special cases first, then pick scan or skip search
      ST_DECIDE: begin
        if (stat_i.pc_zero) begin
          op      = stat_i.off_lt_tc ? OP_HIT_OFF : OP_MISS;
          state_d = ST_IDLE;
        end else if (stat_i.pc_gt_tc) begin
          op      = OP_MISS;
          state_d = ST_IDLE;
        end else if (stat_i.pc_one) begin
          state_d = ST_SCAN_RD;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_SCAN_RD: begin
        if (!stat_i.j_lt_tc) begin
          op      = OP_MISS;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (stat_i.byte_eq) begin
          op      = OP_HIT_J;
          state_d = ST_IDLE;
        end else begin
          op      = OP_SCAN_NEXT;
          state_d = ST_SCAN_RD;
        end
      end
      ST_FILL: begin
        op = OP_FILL;
        if (stat_i.fill_last) state_d = ST_BLD_RD;
      end
      ST_BLD_RD: begin
        op      = OP_BLD_RD;
        state_d = ST_BLD_WR;
      end
      ST_BLD_WR: begin
        op      = OP_BLD_WR;
        state_d = stat_i.bld_last ? ST_CHK : ST_BLD_RD;
      end
      ST_CHK: begin
        if (stat_i.k_lt_tc) begin
          op      = OP_LOAD_J;
          state_d = ST_CMP_RD;
        end else begin
          op      = OP_MISS;
          state_d = ST_IDLE;
        end
      end
      ST_CMP_RD: state_d = ST_CMP;
      ST_CMP: begin
        if (stat_i.byte_eq && stat_i.pi_zero) begin
          op      = OP_HIT_J;
          state_d = ST_IDLE;
        end else begin
          op      = OP_CMP_STEP;
          state_d = stat_i.byte_eq ? ST_CMP_RD : ST_SKIP_RD;
        end
      end
      ST_SKIP_RD: state_d = ST_SHIFT;
      ST_SHIFT: begin
        op      = OP_SHIFT;
        state_d = ST_CHK;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign fin = (op == OP_HIT_OFF) || (op == OP_HIT_J) || (op == OP_MISS);

  // State and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
      if (op == OP_INIT) busy_q <= 1'b1;
      else if (fin)      busy_q <= 1'b0;
    end
  end

  assign op_o   = op;
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

### rtl/horspool_substring_search.sv
// ----------------------------------------------------------------------------
// horspool_substring_search
// Byte substring search over a text store and a pattern store.
// ----------------------------------------------------------------------------
// Clear and append transactions leave busy low, so they can be issued back
// to back. A search raises busy the cycle after it is taken. It ends with a
// one-cycle done_o strobe carrying res_o, in the same cycle that busy falls.
// The strobe cannot be held off, so capture it when it shows. While busy, a
// search steps as follows:
// - empty pattern: a hit at the start offset if it lies inside the text,
//   else a miss; pattern longer than text: a miss;
// - one-byte pattern: each text byte from the start offset is read and
//   compared in turn, ending on a bounds check when nothing matches;
// - longer patterns: the skip table is refilled for all 256 byte values,
//   then built from the P-1 leading pattern bytes, where P is the pattern
//   length. Each window is compared from its right end, with a shift after a mismatch; a miss ends on a bounds check.
// Every store read is registered, so each read has its own state.
// ----------------------------------------------------------------------------
module horspool_substring_search import hss_pkg::*; #(
  parameter int TEXT_MAX    = TextMaxDef,
  parameter int PATTERN_MAX = PatternMaxDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  hss_req_t req_i,
  output logic     busy,
  output logic     done_o,
  output hss_res_t res_o
);

  hss_op_e   op;
  hss_stat_t stat;

  // Sequencer
  hss_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (req_i.func),
    .stat_i  (stat),
    .op_o    (op),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Stores and search datapath
  hss_dpath #(
    .TEXT_MAX    (TEXT_MAX),
    .PATTERN_MAX (PATTERN_MAX)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (op),
    .req_i  (req_i),
    .stat_o (stat),
    .res_o  (res_o)
  );

endmodule

### rtl/hss_checker.sv
// ----------------------------------------------------------------------------
// hss_checker
// Port-level checks of the search block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hss_checker import hss_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input hss_req_t req_i,
  input logic     busy,
  input logic     done_o,
  input hss_res_t res_o
);

  logic srch_take, store_take, miss_shown;

  // Accepted transactions by kind, and a reported miss
  assign srch_take  = start && !busy && (req_i.func == FUNC_SEARCH);
  assign store_take = start && !busy && (req_i.func != FUNC_SEARCH);
  assign miss_shown = done_o && !res_o.found;

  // A search transaction makes the block busy
  `HSS_ASSERT_NXT(a_search_busy, clk_i, rst_ni, srch_take, busy)

  // Store transactions neither block nor produce a result
  `HSS_ASSERT_NXT(a_store_quiet, clk_i, rst_ni, store_take, !busy && !done_o)

  // The result strobe comes with busy already released
  `HSS_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy)

  // The strobe lasts exactly one cycle
  `HSS_ASSERT_NXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o)

  // A miss reports position zero
  `HSS_ASSERT_IMP(a_miss_pos, clk_i, rst_ni, miss_shown, res_o.match_position == '0)

endmodule

bind horspool_substring_search hss_checker u_hss_checker (.*);
